// File: sv/led_pulse_width_serializer_assert.svh
// Assertion macros used by the serializer engine
`ifndef LED_PULSE_WIDTH_SERIALIZER_ASSERT_SVH
`define LED_PULSE_WIDTH_SERIALIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LPWS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define LPWS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lpws_pkg.sv
// Package: types and constants of the pulse-width serializer
`timescale 1ns / 1ps
package lpws_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BIT_CNT_W     = 4;
   localparam int unsigned CYCLE_CNT_W   = 16;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned CSR_INDEX_W   = 2;

   localparam logic [7:0]  RST_BIT_PERIOD  = 8'd20;
   localparam logic [7:0]  RST_HIGH_ONE    = 8'd13;
   localparam logic [7:0]  RST_HIGH_ZERO   = 8'd6;
   localparam logic [15:0] RST_RESET_LOW   = 16'd800;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PERIOD = 2'd0,
      CSR_HIGH_ONE   = 2'd1,
      CSR_HIGH_ZERO  = 2'd2,
      CSR_RESET_LOW  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEND  = 2'd1,
      PH_RESET = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  bit_period_cycles;
      logic [7:0]  high_cycles_one;
      logic [7:0]  high_cycles_zero;
      logic [15:0] reset_low_cycles;
   } cfg_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic byte_accepted;
      logic busy_res;
   } rsp_type;

endpackage

// File: sv/lpws_csr.sv
// Configuration registers of the serializer
`timescale 1ns / 1ps
module lpws_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lpws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lpws_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output lpws_pkg::cfg_type                  cfg
);
   import lpws_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BIT_PERIOD: cfg_in.bit_period_cycles = csr_wdata[7:0];
            CSR_HIGH_ONE:   cfg_in.high_cycles_one   = csr_wdata[7:0];
            CSR_HIGH_ZERO:  cfg_in.high_cycles_zero  = csr_wdata[7:0];
            CSR_RESET_LOW:  cfg_in.reset_low_cycles  = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period_cycles <= RST_BIT_PERIOD;
         cfg_ff.high_cycles_one   <= RST_HIGH_ONE;
         cfg_ff.high_cycles_zero  <= RST_HIGH_ZERO;
         cfg_ff.reset_low_cycles  <= RST_RESET_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/lpws_in_reg.sv
// Input register stage of the serializer
`timescale 1ns / 1ps
module lpws_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpws_pkg::req_type req_payload,
   input  logic              take,
   output logic              item_valid,
   output lpws_pkg::req_type item
);
   import lpws_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // free when empty or when the held word moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/lpws_engine.sv
// Line timing engine: holding register, shifter and symbol counters
`timescale 1ns / 1ps
module lpws_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  lpws_pkg::req_type item,
   input  lpws_pkg::cfg_type cfg,
   output lpws_pkg::rsp_type result
);
   import lpws_pkg::*;

   `include "led_pulse_width_serializer_assert.svh"

   logic [BITS_PER_BYTE-1:0] shift_ff,  shift_in;
   logic [BIT_CNT_W-1:0]     remain_ff, remain_in;
   logic [CYCLE_CNT_W-1:0]   count_ff,  count_in;
   logic [BITS_PER_BYTE-1:0] held_byte_ff, held_byte_in;
   logic                     held_valid_ff, held_valid_in;
   logic                     held_last_ff,  held_last_in;
   logic                     cur_last_ff,   cur_last_in;
   phase_type                phase_ff,      phase_in;

   always_comb begin
      logic                     load;
      logic [BITS_PER_BYTE-1:0] sb;
      logic [BIT_CNT_W-1:0]     br;
      logic [BIT_CNT_W-1:0]     br_dec;
      logic [CYCLE_CNT_W-1:0]   cc;
      logic                     cl;
      logic                     hv;
      phase_type                ph;
      logic [7:0]               high;
      logic [7:0]               period;
      logic [CYCLE_CNT_W-1:0]   len;
      logic [CYCLE_CNT_W:0]     cc_inc;
      logic                     accept;

      // start a held word when idle
      load = (phase_ff == PH_IDLE) && held_valid_ff;
      sb   = load ? held_byte_ff : shift_ff;
      br   = load ? BIT_CNT_W'(BITS_PER_BYTE) : remain_ff;
      cc   = load ? '0 : count_ff;
      cl   = load ? held_last_ff : cur_last_ff;
      hv   = load ? 1'b0 : held_valid_ff;
      ph   = load ? PH_SEND : phase_ff;

      high = sb[BITS_PER_BYTE-1] ? cfg.high_cycles_one : cfg.high_cycles_zero;
      result.line_level = (ph == PH_SEND) && (cc < {8'd0, high});
      result.busy_res   = (ph != PH_IDLE);

      accept = item.byte_valid && !hv;
      result.byte_accepted = accept;

      held_valid_in = hv || accept;
      held_byte_in  = accept ? item.data_byte : held_byte_ff;
      held_last_in  = accept ? item.last_byte : held_last_ff;

      shift_in    = sb;
      remain_in   = br;
      count_in    = cc;
      cur_last_in = cl;
      phase_in    = ph;

      period = (cfg.bit_period_cycles == 8'd0) ? 8'd1 : cfg.bit_period_cycles;
      len    = (cfg.reset_low_cycles == '0) ? CYCLE_CNT_W'(1) : cfg.reset_low_cycles;
      cc_inc = {1'b0, cc} + (CYCLE_CNT_W+1)'(1);
      br_dec = br - BIT_CNT_W'(1);

      case (ph)
         PH_SEND: begin
            if (cc_inc >= {9'd0, period}) begin
               count_in  = '0;
               shift_in  = {sb[BITS_PER_BYTE-2:0], 1'b0};
               remain_in = br_dec;
               if (br_dec == '0) begin
                  if (!cl && held_valid_in) begin
                     // next word follows without a gap
                     shift_in      = held_byte_in;
                     remain_in     = BIT_CNT_W'(BITS_PER_BYTE);
                     cur_last_in   = held_last_in;
                     held_valid_in = 1'b0;
                     phase_in      = PH_SEND;
                  end else begin
                     phase_in = PH_RESET;
                  end
               end
            end else begin
               count_in = cc_inc[CYCLE_CNT_W-1:0];
            end
         end
         PH_RESET: begin
            if (cc_inc >= {1'b0, len}) begin
               count_in = '0;
               phase_in = PH_IDLE;
            end else begin
               count_in = cc_inc[CYCLE_CNT_W-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         remain_ff     <= '0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_last_ff  <= 1'b0;
         cur_last_ff   <= 1'b0;
         phase_ff      <= PH_IDLE;
      end else if (step) begin
         shift_ff      <= shift_in;
         remain_ff     <= remain_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         held_last_ff  <= held_last_in;
         cur_last_ff   <= cur_last_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_byte_ff <= held_byte_in;
      end
   end

   `LPWS_ASSERT_NOW(a_send_has_bits, clock, reset,
      phase_ff == PH_SEND, remain_ff != '0, "sending with no bits left")
   `LPWS_ASSERT_NOW(a_idle_count_clear, clock, reset,
      phase_ff == PH_IDLE, count_ff == '0, "idle with cycle count running")
   `LPWS_ASSERT_NEXT(a_accept_fills_hold, clock, reset,
      step && result.byte_accepted, held_valid_ff || phase_ff == PH_SEND,
      "accepted word lost from holding register")

endmodule

// File: sv/lpws_out_reg.sv
// Result register stage of the serializer
`timescale 1ns / 1ps
module lpws_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   output logic              load_ready,
   input  lpws_pkg::rsp_type result,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpws_pkg::rsp_type rsp_payload
);
   import lpws_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = word_ff;

endmodule

// File: sv/led_pulse_width_serializer.sv
// Top level of the pulse-width LED line serializer
`timescale 1ns / 1ps
// Each request word is one tick of the LED line timing and may offer a colour
// byte (byte_valid, data_byte, last_byte). Each response word reports that
// tick: line level, whether the offered byte entered the holding register, and
// busy. Bytes go out msb first as pulse-width symbols; after the byte marked
// last, or on underrun, the line is held low for reset_low_cycles ticks.
// Channels: req_ and rsp_ use valid/ready; csr_ is a plain write port
// (index 0 bit period, 1 high ticks of a one, 2 high ticks of a zero,
// 3 reset low ticks), written only while the block is idle: a rule for the user
// that the block itself does not enforce. An accepted request word is captured
// in the input register, then its response word in the result register.
// Throughput: one word per cycle outside stalls (single state update per tick).
// Reset clears the line state to idle and loads the default timing.
// When the receiver stalls the result register holds, the input register
// fills, and req_ready drops until the result is taken.
module led_pulse_width_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lpws_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lpws_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [lpws_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpws_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lpws_pkg::*;

   cfg_type cfg;
   req_type item;
   rsp_type result;
   logic    item_valid;
   logic    load_ready;
   logic    step;

   assign step = item_valid && load_ready;

   lpws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpws_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .take        (step),
      .item_valid  (item_valid),
      .item        (item)
   );

   lpws_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   lpws_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .load_ready  (load_ready),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: verif/led_pulse_width_serializer_tb.sv
// Testbench: LED line serializer checked tick by tick against a behavioural predictor
`timescale 1ns / 1ps
module led_pulse_width_serializer_tb;
   import lpws_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned RANDOM_TICKS  = 340;
   localparam int unsigned REPORT_MAX    = 10;
   localparam int unsigned IDLE_PCT      = 14;
   localparam int unsigned QUEUE_AHEAD   = 3;
   localparam int unsigned SETTLE_CYCLES = 4;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   // line ticks waiting to be driven, and the responses they must produce
   req_type     pending_ticks[$];
   rsp_type     expected_ticks[$];
   int unsigned ticks_pushed  = 0;
   int unsigned ticks_done    = 0;
   int unsigned rsp_seen      = 0;
   int unsigned mismatch_cnt  = 0;
   int unsigned bytes_taken   = 0;
   logic        last_taken    = 1'b0;
   logic        steady_run    = 1'b0;

   // predictor state
   cfg_type     line_cfg;
   logic [7:0]  shifter;
   logic [3:0]  bits_left;
   int unsigned tick_cnt;
   logic [7:0]  held_byte;
   logic        held_full;
   logic        held_last;
   logic        cur_last;
   phase_type   line_phase;

   led_pulse_width_serializer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reset_line_model();
      line_cfg.bit_period_cycles = RST_BIT_PERIOD;
      line_cfg.high_cycles_one   = RST_HIGH_ONE;
      line_cfg.high_cycles_zero  = RST_HIGH_ZERO;
      line_cfg.reset_low_cycles  = RST_RESET_LOW;
      shifter    = '0;
      bits_left  = '0;
      tick_cnt   = 0;
      held_byte  = '0;
      held_full  = 1'b0;
      held_last  = 1'b0;
      cur_last   = 1'b0;
      line_phase = PH_IDLE;
   endfunction

   function automatic void load_shifter();
      shifter    = held_byte;
      bits_left  = 4'(BITS_PER_BYTE);
      tick_cnt   = 0;
      cur_last   = held_last;
      held_full  = 1'b0;
      line_phase = PH_SEND;
   endfunction

   // one tick of the line: returns the response word and advances the state
   function automatic rsp_type line_tick(req_type w);
      rsp_type     r;
      logic [7:0]  high_ticks;
      int unsigned period;
      int unsigned low_len;
      r = '0;
      if (line_phase == PH_IDLE && held_full) load_shifter();
      if (line_phase == PH_SEND) begin
         high_ticks   = shifter[7] ? line_cfg.high_cycles_one : line_cfg.high_cycles_zero;
         r.line_level = (tick_cnt < 32'(high_ticks));
      end
      r.busy_res = (line_phase != PH_IDLE);
      // a register emptied by the load above can take a byte on this tick
      if (w.byte_valid && !held_full) begin
         held_byte       = w.data_byte;
         held_last       = w.last_byte;
         held_full       = 1'b1;
         r.byte_accepted = 1'b1;
         bytes_taken++;
         if (w.last_byte) last_taken = 1'b1;
      end
      case (line_phase)
         PH_SEND: begin
            period = (line_cfg.bit_period_cycles == 8'd0) ? 1 :
                     32'(line_cfg.bit_period_cycles);
            tick_cnt++;
            if (tick_cnt >= period) begin
               tick_cnt  = 0;
               shifter   = shifter << 1;
               bits_left = bits_left - 4'd1;
               if (bits_left == 4'd0) begin
                  if (!cur_last && held_full) begin
                     load_shifter();
                  end else begin
                     line_phase = PH_RESET;
                     tick_cnt   = 0;
                  end
               end
            end
         end
         PH_RESET: begin
            low_len = (line_cfg.reset_low_cycles == 16'd0) ? 1 :
                      32'(line_cfg.reset_low_cycles);
            tick_cnt++;
            if (tick_cnt >= low_len) begin
               tick_cnt   = 0;
               line_phase = PH_IDLE;
            end
         end
         default: line_phase = PH_IDLE;
      endcase
      return r;
   endfunction

   // driver: advance to the next queued word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_ticks.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on every accepted request word, check every response word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_ticks.push_back(line_tick(req_payload));
            ticks_done++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_ticks.size() == 0) begin
               if (mismatch_cnt < REPORT_MAX)
                  $display("word %0d: unexpected response line %b taken %b busy %b", rsp_seen,
                           rsp_payload.line_level, rsp_payload.byte_accepted,
                           rsp_payload.busy_res);
               mismatch_cnt++;
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_payload.line_level !== want.line_level ||
                   rsp_payload.byte_accepted !== want.byte_accepted ||
                   rsp_payload.busy_res !== want.busy_res) begin
                  if (mismatch_cnt < REPORT_MAX)
                     $display("word %0d: expected line %b taken %b busy %b, got %b %b %b",
                              rsp_seen, want.line_level, want.byte_accepted, want.busy_res,
                              rsp_payload.line_level, rsp_payload.byte_accepted,
                              rsp_payload.busy_res);
                  mismatch_cnt++;
               end
            end
         end
         rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic void queue_word(logic v, logic [7:0] d, logic l);
      req_type w;
      w.byte_valid = v;
      w.data_byte  = d;
      w.last_byte  = l;
      pending_ticks.push_back(w);
      ticks_pushed++;
   endfunction

   task automatic wait_ticks_done();
      while (ticks_done != ticks_pushed) @(negedge clock);
   endtask

   // keep offering one byte, one word at a time, until the holding register takes it
   task automatic offer_byte(logic [7:0] d, logic l);
      int unsigned start_cnt;
      wait_ticks_done();
      start_cnt = bytes_taken;
      while (bytes_taken == start_cnt) begin
         queue_word(1'b1, d, l);
         wait_ticks_done();
      end
   endtask

   // feed empty ticks until the line is idle and every response is back
   task automatic drain_to_idle();
      while (!(line_phase == PH_IDLE && !held_full && ticks_done == ticks_pushed)) begin
         if ((line_phase != PH_IDLE || held_full) && pending_ticks.size() < QUEUE_AHEAD)
            queue_word(1'b0, 8'($urandom), 1'($urandom));
         @(negedge clock);
      end
      while (expected_ticks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_BIT_PERIOD: line_cfg.bit_period_cycles = v[7:0];
         CSR_HIGH_ONE:   line_cfg.high_cycles_one   = v[7:0];
         CSR_HIGH_ZERO:  line_cfg.high_cycles_zero  = v[7:0];
         default:        line_cfg.reset_low_cycles  = v;
      endcase
      @(negedge clock);
   endtask

   // upper bits of the 8-bit registers get random junk, which must be dropped
   task automatic set_timing(logic [7:0] bp, logic [7:0] hi1, logic [7:0] hi0,
                             logic [15:0] rl);
      drain_to_idle();
      write_reg(CSR_BIT_PERIOD, {8'($urandom), bp});
      write_reg(CSR_HIGH_ONE,   {8'($urandom), hi1});
      write_reg(CSR_HIGH_ZERO,  {8'($urandom), hi0});
      write_reg(CSR_RESET_LOW,  rl);
   endtask

   // stream random bytes until n are taken, then mark one last or let it underrun
   task automatic stream_frame(int unsigned n, int unsigned density, logic with_last);
      int unsigned start_cnt;
      logic        v;
      start_cnt  = bytes_taken;
      last_taken = 1'b0;
      while (bytes_taken - start_cnt < n) begin
         if (pending_ticks.size() < QUEUE_AHEAD) begin
            v = ($urandom_range(99) < density);
            queue_word(v, 8'($urandom), v ? 1'b0 : 1'($urandom));
         end
         @(negedge clock);
      end
      if (with_last) begin
         while (!last_taken) begin
            if (pending_ticks.size() < QUEUE_AHEAD) queue_word(1'b1, 8'($urandom), 1'b1);
            @(negedge clock);
         end
      end
   endtask

   initial begin
      int unsigned rand_start;
      int unsigned phase_no;
      int unsigned density;
      int unsigned pick;
      int unsigned frames;
      logic [7:0]  bp;
      logic [7:0]  hi1;
      logic [7:0]  hi0;
      logic [15:0] rl;
      reset_line_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default symbol timing, with a short reset low to keep the frame brief
      write_reg(CSR_RESET_LOW, 16'd12);
      offer_byte(8'h96, 1'b1);
      // alternating bits; the trailing byte waits out the reset low, then underruns
      set_timing(8'd4, 8'd3, 8'd1, 16'd5);
      offer_byte(8'hAA, 1'b0);
      offer_byte(8'h55, 1'b1);
      offer_byte(8'h81, 1'b0);
      // zero period, zero high for a zero bit, zero reset length
      set_timing(8'd0, 8'd1, 8'd0, 16'd0);
      offer_byte(8'hF0, 1'b1);
      // one tick per symbol
      set_timing(8'd1, 8'd2, 8'd1, 16'd3);
      offer_byte(8'h0F, 1'b0);
      offer_byte(8'h3C, 1'b1);
      // high counts at and above the period
      set_timing(8'd3, 8'd9, 8'd3, 16'd2);
      offer_byte(8'hC3, 1'b1);
      // high count of 254 and a reset low beyond eight bits
      set_timing(8'd2, 8'd254, 8'd1, 16'd257);
      offer_byte(8'h80, 1'b1);

      rand_start = ticks_pushed;
      phase_no   = 0;
      while (ticks_pushed - rand_start < RANDOM_TICKS) begin
         bp  = ($urandom_range(99) < 75) ? 8'($urandom_range(4)) : 8'($urandom_range(10, 5));
         hi1 = 8'($urandom_range(32'(bp) + 2));
         hi0 = 8'($urandom_range(32'(bp) + 2));
         rl  = ($urandom_range(99) < 85) ? 16'($urandom_range(12)) :
                                          16'($urandom_range(40, 13));
         set_timing(bp, hi1, hi0, rl);
         steady_run = (phase_no == 1);
         frames     = $urandom_range(3, 1);
         while (frames != 0 && ticks_pushed - rand_start < RANDOM_TICKS) begin
            pick = $urandom_range(99);
            if (pick < 70)      density = $urandom_range(100, 85);
            else if (pick < 90) density = $urandom_range(70, 30);
            else                density = $urandom_range(10, 3);
            stream_frame($urandom_range(4, 1), density, $urandom_range(99) < 80);
            frames--;
         end
         phase_no++;
      end
      steady_run = 1'b0;

      // high count above the period, never-high zeros, shortest reset
      set_timing(8'd6, 8'd255, 8'd0, 16'd0);
      stream_frame(1, 100, 1'b1);
      drain_to_idle();

      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/lpws_pkg.sv
sv/lpws_csr.sv
sv/lpws_in_reg.sv
sv/lpws_engine.sv
sv/lpws_out_reg.sv
sv/led_pulse_width_serializer.sv
verif/led_pulse_width_serializer_tb.sv
